// ----- src/bls_pkg.sv -----
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types and constants for the Bresenham line stepper.
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int COORD_BITS = 12;
  localparam int ERR_BITS   = COORD_BITS + 2;
  localparam int ERR2_BITS  = ERR_BITS + 1;
  localparam int CMD_DEPTH  = 4;
  localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_BITS = $clog2(CMD_DEPTH + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-1:0] delta_t;
  typedef logic signed [ERR_BITS-1:0]   err_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  // A classified command as it waits between the front and the back.
  typedef struct packed {
    logic   is_load;
    coord_t start_u;
    coord_t start_v;
    coord_t end_u;
    coord_t end_v;
    delta_t delta_u;
    delta_t delta_v;
    err_t   error_init;
    logic   neg_u;
    logic   neg_v;
    logic   active;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  typedef struct packed {
    coord_t pixel_u;
    coord_t pixel_v;
    logic   last_pixel;
  } result_t;

endpackage

// ----- src/bls_front.sv -----
// ----------------------------------------------------------------------------
// bls_front
// Accepts input beats and classifies them; load beats get their deltas, step
// directions and initial error term worked out here.
// ----------------------------------------------------------------------------
module bls_front (
  input  logic                    push,
  input  logic                    op,
  input  bls_pkg::coord_t         start_u,
  input  bls_pkg::coord_t         start_v,
  input  bls_pkg::coord_t         end_u,
  input  bls_pkg::coord_t         end_v,
  input  bls_pkg::queue_status_t  cmd_status,
  output logic                    cmd_write,
  output bls_pkg::cmd_t           cmd
);

  logic signed [bls_pkg::COORD_BITS:0] diff_u;
  logic signed [bls_pkg::COORD_BITS:0] diff_v;
  bls_pkg::delta_t                     abs_u;
  bls_pkg::delta_t                     abs_v;

  assign cmd_write = push && !cmd_status.full;

  always_comb begin
    diff_u = {end_u[bls_pkg::COORD_BITS-1], end_u} - {start_u[bls_pkg::COORD_BITS-1], start_u};
    diff_v = {end_v[bls_pkg::COORD_BITS-1], end_v} - {start_v[bls_pkg::COORD_BITS-1], start_v};
    abs_u  = diff_u[bls_pkg::COORD_BITS] ? bls_pkg::delta_t'(-diff_u)
                                         : bls_pkg::delta_t'(diff_u);
    abs_v  = diff_v[bls_pkg::COORD_BITS] ? bls_pkg::delta_t'(-diff_v)
                                         : bls_pkg::delta_t'(diff_v);

    cmd.is_load    = (op == bls_pkg::OP_LOAD);
    cmd.start_u    = start_u;
    cmd.start_v    = start_v;
    cmd.end_u      = end_u;
    cmd.end_v      = end_v;
    cmd.delta_u    = abs_u;
    cmd.delta_v    = abs_v;
    cmd.error_init = $signed({2'b00, abs_u}) - $signed({2'b00, abs_v});
    cmd.neg_u      = (start_u >= end_u);
    cmd.neg_v      = (start_v >= end_v);
    cmd.active     = (start_u != end_u) || (start_v != end_v);
  end

endmodule

// ----- src/bls_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// bls_cmd_queue
// Short queue of classified commands between the front and the back.
// ----------------------------------------------------------------------------
module bls_cmd_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  bls_pkg::cmd_t           wr_cmd,
  input  logic                    rd_en,
  output bls_pkg::cmd_t           rd_cmd,
  output bls_pkg::queue_status_t  status
);

  bls_pkg::cmd_t                      entries [bls_pkg::CMD_DEPTH];
  logic [bls_pkg::CMD_PTR_BITS-1:0]   wr_ptr;
  logic [bls_pkg::CMD_PTR_BITS-1:0]   rd_ptr;
  logic [bls_pkg::CMD_CNT_BITS-1:0]   count;
  logic                               do_wr;
  logic                               do_rd;

  assign status.empty = (count == '0);
  assign status.full  = (count == bls_pkg::CMD_CNT_BITS'(bls_pkg::CMD_DEPTH));
  assign do_wr = wr_en && !status.full;
  assign do_rd = rd_en && !status.empty;
  assign rd_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/bls_back.sv -----
// ----------------------------------------------------------------------------
// bls_back
// Carries out commands: loads the line state or takes one Bresenham step,
// and queues emitted pixels in a two-entry result buffer.
// ----------------------------------------------------------------------------
module bls_back (
  input  logic                    clk,
  input  logic                    rst,
  input  bls_pkg::cmd_t           cmd,
  input  bls_pkg::queue_status_t  cmd_status,
  output logic                    cmd_read,
  input  logic                    pop,
  output logic                    empty,
  output bls_pkg::result_t        result
);

  bls_pkg::coord_t current_u;
  bls_pkg::coord_t current_v;
  bls_pkg::coord_t target_u;
  bls_pkg::coord_t target_v;
  bls_pkg::delta_t delta_u;
  bls_pkg::delta_t delta_v;
  bls_pkg::err_t   error_term;
  logic            step_u_negative;
  logic            step_v_negative;
  logic            line_active;

  bls_pkg::result_t out_entries [2];
  logic             out_wr_ptr;
  logic             out_rd_ptr;
  logic [1:0]       out_count;
  logic             out_full;
  logic             out_push;
  logic             out_pop;

  logic signed [bls_pkg::ERR2_BITS-1:0] e2;
  logic signed [bls_pkg::ERR2_BITS-1:0] err_sum;
  logic                                 move_u;
  logic                                 move_v;
  bls_pkg::coord_t                      current_u_next;
  bls_pkg::coord_t                      current_v_next;
  bls_pkg::err_t                        error_term_next;
  logic                                 line_active_next;
  logic                                 do_step;

  assign out_full = (out_count == 2'd2);
  assign empty    = (out_count == 2'd0);
  assign out_pop  = pop && !empty;
  assign result   = out_entries[out_rd_ptr];

  // Every command waits for result space, so a step never has to stall midway.
  assign cmd_read = !cmd_status.empty && !out_full;
  assign do_step  = cmd_read && !cmd.is_load && line_active;
  assign out_push = do_step;

  always_comb begin
    e2 = {error_term, 1'b0};
    move_u = e2 > -$signed({3'b000, delta_v});
    move_v = e2 <  $signed({3'b000, delta_u});
    err_sum = bls_pkg::ERR2_BITS'(error_term);
    if (move_u) begin
      err_sum = err_sum - $signed({3'b000, delta_v});
    end
    if (move_v) begin
      err_sum = err_sum + $signed({3'b000, delta_u});
    end
    error_term_next = bls_pkg::err_t'(err_sum);
    current_u_next = current_u;
    current_v_next = current_v;
    if (move_u) begin
      current_u_next = step_u_negative ? current_u - 1'b1 : current_u + 1'b1;
    end
    if (move_v) begin
      current_v_next = step_v_negative ? current_v - 1'b1 : current_v + 1'b1;
    end
    line_active_next = !((current_u_next == target_u) && (current_v_next == target_v));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_u       <= '0;
      current_v       <= '0;
      target_u        <= '0;
      target_v        <= '0;
      delta_u         <= '0;
      delta_v         <= '0;
      error_term      <= '0;
      step_u_negative <= 1'b0;
      step_v_negative <= 1'b0;
      line_active     <= 1'b0;
    end else if (cmd_read && cmd.is_load) begin
      current_u       <= cmd.start_u;
      current_v       <= cmd.start_v;
      target_u        <= cmd.end_u;
      target_v        <= cmd.end_v;
      delta_u         <= cmd.delta_u;
      delta_v         <= cmd.delta_v;
      error_term      <= cmd.error_init;
      step_u_negative <= cmd.neg_u;
      step_v_negative <= cmd.neg_v;
      line_active     <= cmd.active;
    end else if (do_step) begin
      current_u   <= current_u_next;
      current_v   <= current_v_next;
      error_term  <= error_term_next;
      line_active <= line_active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_push) begin
      out_entries[out_wr_ptr].pixel_u    <= current_u;
      out_entries[out_wr_ptr].pixel_v    <= current_v;
      out_entries[out_wr_ptr].last_pixel <= !line_active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr_ptr <= 1'b0;
      out_rd_ptr <= 1'b0;
      out_count  <= 2'd0;
    end else begin
      if (out_push) begin
        out_wr_ptr <= !out_wr_ptr;
      end
      if (out_pop) begin
        out_rd_ptr <= !out_rd_ptr;
      end
      if (out_push && !out_pop) begin
        out_count <= out_count + 2'd1;
      end else if (out_pop && !out_push) begin
        out_count <= out_count - 2'd1;
      end
    end
  end

endmodule

// ----- src/bresenham_line_stepper_top.sv -----
// ----------------------------------------------------------------------------
// bresenham_line_stepper_top
// All-octant Bresenham line stepper with queue-style input and result ports.
// ----------------------------------------------------------------------------
// The block takes one input beat per clock while the command queue is not
// full: a load beat (op = 0) latches a line from start to end, and each step
// beat (op = 1) emits the current pixel and advances it, so a line of N
// pixels is drawn by one load and N steps at one pixel per clock while the
// result buffer has room. The end point itself is never emitted, a
// zero-length line emits nothing, and a step with no active line is absorbed
// without a result. The front classifies each beat and computes the absolute
// deltas, step directions and initial error of a load; a four-entry command
// queue lets it keep taking beats while the back stalls. The back applies one
// command per clock while the result buffer has room, and places each pixel
// in a two-entry result buffer, so a beat is accepted even while a finished
// pixel waits to be popped. The back only stalls while both result entries
// are waiting. A step beat is written into the command queue, and its pixel
// is then registered in the result buffer, which drives the result ports.
// Push while full is ignored.
// ----------------------------------------------------------------------------
module bresenham_line_stepper_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic            op,
  input  bls_pkg::coord_t start_u,
  input  bls_pkg::coord_t start_v,
  input  bls_pkg::coord_t end_u,
  input  bls_pkg::coord_t end_v,
  input  logic            pop,
  output logic            empty,
  output bls_pkg::coord_t pixel_u,
  output bls_pkg::coord_t pixel_v,
  output logic            last_pixel
);

  // Command path between the front and the back.
  bls_pkg::cmd_t          front_cmd;
  bls_pkg::cmd_t          queue_cmd;
  bls_pkg::queue_status_t cmd_status;
  logic                   cmd_write;
  logic                   cmd_read;
  bls_pkg::result_t       result;

  bls_front u_front (
    .push       (push),
    .op         (op),
    .start_u    (start_u),
    .start_v    (start_v),
    .end_u      (end_u),
    .end_v      (end_v),
    .cmd_status (cmd_status),
    .cmd_write  (cmd_write),
    .cmd        (front_cmd)
  );

  bls_cmd_queue u_cmd_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (cmd_write),
    .wr_cmd (front_cmd),
    .rd_en  (cmd_read),
    .rd_cmd (queue_cmd),
    .status (cmd_status)
  );

  bls_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd        (queue_cmd),
    .cmd_status (cmd_status),
    .cmd_read   (cmd_read),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

  // The input side reports full exactly when the command queue has no room.
  assign full       = cmd_status.full;
  assign pixel_u    = result.pixel_u;
  assign pixel_v    = result.pixel_v;
  assign last_pixel = result.last_pixel;

endmodule

// ----- src/bls_checker.sv -----
// ----------------------------------------------------------------------------
// bls_checker
// Port-level assertions for the Bresenham line stepper, bound to the top.
// ----------------------------------------------------------------------------
module bls_checker (
  input logic            clk,
  input logic            rst,
  input logic            push,
  input logic            full,
  input logic            pop,
  input logic            empty,
  input bls_pkg::coord_t pixel_u,
  input bls_pkg::coord_t pixel_v,
  input logic            last_pixel
);

  // Reset leaves both queues empty.
  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // A waiting pixel that is not popped stays on the ports unchanged.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(pixel_u) && $stable(pixel_v)
                          && $stable(last_pixel)))
    else $error("waiting result changed without a pop");

  // The command queue can only fill up after an accepted beat.
  a_full_after_push: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push))
    else $error("full rose without a push");

endmodule

bind bresenham_line_stepper_top bls_checker u_bls_checker (
  .clk        (clk),
  .rst        (rst),
  .push       (push),
  .full       (full),
  .pop        (pop),
  .empty      (empty),
  .pixel_u    (pixel_u),
  .pixel_v    (pixel_v),
  .last_pixel (last_pixel)
);
